// File: design/gf2m_field_arithmetic_unit_core_assert.svh
// Assertion macros used by the checker file of the GF(2^m) unit.
`ifndef GF2M_FIELD_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define GF2M_FIELD_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define GF2M_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define GF2M_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gf2m_pkg.sv
// ----------------------------------------------------------------------------
// gf2m_pkg
// Shared constants, codes and controller/datapath command types for the
// GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
package gf2m_pkg;

    localparam int FIELD_W              = 64;
    localparam int DEG_W                = 7;
    localparam int CFG_IDX_W            = 1;
    localparam int DEFAULT_OPERAND_BITS = 64;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_RED = 2'd2;
    localparam logic [1:0] OP_INV = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_TAIL   = 1'b1;

    localparam logic [DEG_W-1:0]   DEG_RESET  = 7'd8;
    localparam logic [DEG_W-1:0]   DEG_MIN    = 7'd2;
    localparam logic [DEG_W-1:0]   DEG_MAX    = 7'd64;
    localparam logic [FIELD_W-1:0] TAIL_RESET = 64'd27;

    // Result source selection.
    typedef logic [1:0] res_sel_t;
    localparam res_sel_t SEL_ACC = 2'd0;
    localparam res_sel_t SEL_INV = 2'd1;
    localparam res_sel_t SEL_ERR = 2'd2;

    typedef struct packed {
        logic     load;
        logic     red_step;
        logic     mul_init;
        logic     mul_step;
        logic     inv_init;
        logic     inv_step;
        logic     finish;
        res_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       inv_done;
        logic       inv_fail;
    } dp_status_t;

    // Multiply a reduced value by x modulo P.
    function automatic logic [FIELD_W-1:0] times_x(
        input logic [FIELD_W-1:0] r,
        input logic [FIELD_W-1:0] mask,
        input logic [FIELD_W-1:0] tbit,
        input logic [FIELD_W-1:0] tail
    );
        logic [FIELD_W-1:0] s;
        s = {r[FIELD_W-2:0], 1'b0} & mask;
        if ((r & tbit) != '0)
        begin
            s = s ^ tail;
        end
        return s;
    endfunction

endpackage

// File: design/gf2m_dp.sv
// ----------------------------------------------------------------------------
// gf2m_dp
// Datapath: configuration registers, serial Horner reducer and multiplier,
// shift-aligned Euclidean inverter and the output register.
// ----------------------------------------------------------------------------
module gf2m_dp #(
    parameter int OPERAND_BITS = gf2m_pkg::DEFAULT_OPERAND_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [gf2m_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gf2m_pkg::FIELD_W-1:0]         cfg_data,
    input  logic [1:0]                           op,
    input  logic [OPERAND_BITS-1:0]              operand_a,
    input  logic [OPERAND_BITS-1:0]              operand_b,
    input  gf2m_pkg::dp_cmd_t                    cmd,
    output gf2m_pkg::dp_status_t                 status,
    output logic [gf2m_pkg::FIELD_W-1:0]         result,
    output logic                                 error
);
    import gf2m_pkg::*;

    localparam int WIDE_W = 2 * FIELD_W;

    logic [DEG_W-1:0]        poly_degree_reg;
    logic [FIELD_W-1:0]      poly_tail_reg;

    logic [DEG_W-1:0]        m_eff;
    logic [FIELD_W-1:0]      mask_w;
    logic [FIELD_W-1:0]      tbit_w;

    logic [DEG_W-1:0]        m_reg, m_next;
    logic [FIELD_W-1:0]      mask_reg, mask_next;
    logic [FIELD_W-1:0]      tbit_reg, tbit_next;
    logic [FIELD_W-1:0]      tail_reg, tail_next;
    logic [1:0]              op_reg, op_next;
    logic [OPERAND_BITS-1:0] src_reg, src_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;
    logic [FIELD_W-1:0]      ared_reg, ared_next;
    logic [FIELD_W-1:0]      r_reg, r_next;
    logic [FIELD_W:0]        u_reg, u_next;
    logic [FIELD_W:0]        v_reg, v_next;
    logic [WIDE_W-1:0]       h1_reg, h1_next;
    logic [WIDE_W-1:0]       h2_reg, h2_next;
    logic [DEG_W-1:0]        du_reg, du_next;
    logic [DEG_W-1:0]        dv_reg, dv_next;
    logic [FIELD_W-1:0]      result_reg, result_next;
    logic                    error_reg, error_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= DEG_RESET;
            poly_tail_reg   <= TAIL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POLY_DEGREE: poly_degree_reg <= cfg_data[DEG_W-1:0];
                CFG_POLY_TAIL:   poly_tail_reg   <= cfg_data;
                default:         poly_tail_reg   <= poly_tail_reg;
            endcase
        end
    end

    // Effective degree and its masks, captured when an item is loaded.
    always_comb
    begin
        if (poly_degree_reg < DEG_MIN)
        begin
            m_eff = DEG_MIN;
        end
        else if (poly_degree_reg > DEG_MAX)
        begin
            m_eff = DEG_MAX;
        end
        else
        begin
            m_eff = poly_degree_reg;
        end
        mask_w = {FIELD_W{1'b1}} >> (DEG_MAX - m_eff);
        tbit_w = {{(FIELD_W-1){1'b0}}, 1'b1} << (m_eff - 7'd1);
    end

    // Next-state logic of the datapath.
    always_comb
    begin
        m_next      = m_reg;
        mask_next   = mask_reg;
        tbit_next   = tbit_reg;
        tail_next   = tail_reg;
        op_next     = op_reg;
        src_next    = src_reg;
        b_next      = b_reg;
        ared_next   = ared_reg;
        r_next      = r_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        du_next     = du_reg;
        dv_next     = dv_reg;
        result_next = result_reg;
        error_next  = error_reg;

        if (cmd.load)
        begin
            m_next    = m_eff;
            mask_next = mask_w;
            tbit_next = tbit_w;
            tail_next = poly_tail_reg & mask_w;
            op_next   = op;
            src_next  = (op == OP_ADD) ? (operand_a ^ operand_b) : operand_a;
            b_next    = operand_b;
            r_next    = '0;
        end

        // One Horner step of the reduction, top bit first.
        if (cmd.red_step)
        begin
            r_next   = times_x(r_reg, mask_reg, tbit_reg, tail_reg)
                       ^ {{(FIELD_W-1){1'b0}}, src_reg[OPERAND_BITS-1]};
            src_next = {src_reg[OPERAND_BITS-2:0], 1'b0};
        end

        if (cmd.mul_init)
        begin
            ared_next = r_reg;
            r_next    = '0;
        end

        // One interleaved multiply step, multiplier bits top first.
        if (cmd.mul_step)
        begin
            r_next = times_x(r_reg, mask_reg, tbit_reg, tail_reg)
                     ^ (b_reg[OPERAND_BITS-1] ? ared_reg : '0);
            b_next = {b_reg[OPERAND_BITS-2:0], 1'b0};
        end

        // Operands of the inverter are kept aligned to the top bit.
        if (cmd.inv_init)
        begin
            u_next  = {1'b0, r_reg};
            du_next = DEG_MAX;
            v_next  = {1'b1, {FIELD_W{1'b0}}} | ({1'b0, tail_reg} << (DEG_MAX - m_reg));
            dv_next = m_reg;
            h1_next = {{(WIDE_W-1){1'b0}}, 1'b1};
            h2_next = '0;
        end

        if (cmd.inv_step)
        begin
            if (!u_reg[FIELD_W])
            begin
                u_next  = {u_reg[FIELD_W-1:0], 1'b0};
                h1_next = {h1_reg[WIDE_W-2:0], 1'b0};
                du_next = du_reg - 7'd1;
            end
            else if (du_reg < dv_reg)
            begin
                u_next  = v_reg;
                v_next  = u_reg;
                h1_next = h2_reg;
                h2_next = h1_reg;
                du_next = dv_reg;
                dv_next = du_reg;
            end
            else
            begin
                u_next  = u_reg ^ v_reg;
                h1_next = h1_reg ^ h2_reg;
            end
        end

        if (cmd.finish)
        begin
            case (cmd.sel)
                SEL_INV:
                begin
                    result_next = h1_reg[WIDE_W-1:FIELD_W];
                    error_next  = 1'b0;
                end
                SEL_ERR:
                begin
                    result_next = '0;
                    error_next  = 1'b1;
                end
                default:
                begin
                    result_next = r_reg;
                    error_next  = 1'b0;
                end
            endcase
        end
    end

    // Working registers; control lives in the controller.
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        mask_reg   <= mask_next;
        tbit_reg   <= tbit_next;
        tail_reg   <= tail_next;
        op_reg     <= op_next;
        src_reg    <= src_next;
        b_reg      <= b_next;
        ared_reg   <= ared_next;
        r_reg      <= r_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        result_reg <= result_next;
        error_reg  <= error_next;
    end

    // Status back to the controller.
    assign status.op       = op_reg;
    assign status.inv_done = u_reg[FIELD_W] && (du_reg == '0);
    assign status.inv_fail = (u_reg == '0);

    assign result = result_reg;
    assign error  = error_reg;

endmodule

// File: design/gf2m_ctrl.sv
// ----------------------------------------------------------------------------
// gf2m_ctrl
// Controller: sequences reduction, multiplication and inversion steps and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module gf2m_ctrl #(
    parameter int OPERAND_BITS = gf2m_pkg::DEFAULT_OPERAND_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  gf2m_pkg::dp_status_t status,
    output gf2m_pkg::dp_cmd_t    cmd
);
    import gf2m_pkg::*;

    localparam int CNT_W = $clog2(OPERAND_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_INV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    res_sel_t         sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel        = sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_LAST;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (status.op == OP_MUL || status.op == OP_INV)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        sel_next   = SEL_ACC;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_PREP:
            begin
                if (status.op == OP_MUL)
                begin
                    cmd.mul_init = 1'b1;
                    cnt_next     = CNT_LAST;
                    state_next   = ST_MUL;
                end
                else
                begin
                    cmd.inv_init = 1'b1;
                    state_next   = ST_INV;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    sel_next   = SEL_ACC;
                    state_next = ST_FIN;
                end
            end
            ST_INV:
            begin
                if (status.inv_fail)
                begin
                    sel_next   = SEL_ERR;
                    state_next = ST_FIN;
                end
                else if (status.inv_done)
                begin
                    sel_next   = SEL_INV;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.inv_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= SEL_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/gf2m_field_arithmetic_unit_core.sv
// Add and reduce pass through the one-bit-per-cycle Horner reducer; multiply
// reduces operand A that way and then runs the one-bit-per-cycle multiplier.
// Inverse reduces the operand, then runs Euclid shift, swap and subtract
// steps until the inverse is found or fails. One item at a time; a new item is
// accepted while the previous result waits in the output register.
// Reset clears control; configuration returns to x^8+x^4+x^3+x+1.
// ----------------------------------------------------------------------------
// gf2m_field_arithmetic_unit_core
// Binary-field add, multiply, reduce and invert modulo a configurable P(x).
// ----------------------------------------------------------------------------
module gf2m_field_arithmetic_unit_core #(
    parameter int OPERAND_BITS = gf2m_pkg::DEFAULT_OPERAND_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [gf2m_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gf2m_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [OPERAND_BITS-1:0]        operand_a,
    input  logic [OPERAND_BITS-1:0]        operand_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gf2m_pkg::FIELD_W-1:0]   result,
    output logic                           error
);
    import gf2m_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    gf2m_ctrl #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic.
    gf2m_dp #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .error     (error)
    );

endmodule

// File: design/gf2m_chk.sv
// ----------------------------------------------------------------------------
// gf2m_chk
// Port-level checker for the GF(2^m) unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "gf2m_field_arithmetic_unit_core_assert.svh"

module gf2m_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [gf2m_pkg::FIELD_W-1:0] result,
    input logic                         error
);
    // A stalled result beat is held.
    `GF2M_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `GF2M_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(result) && $stable(error), "stalled result changed")
    // An error beat carries a zero result.
    `GF2M_ASSERT_NOW(a_err_zero, out_valid && error, result == '0, "error beat with nonzero result")
    // The unit works on one item at a time.
    `GF2M_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

bind gf2m_field_arithmetic_unit_core gf2m_chk u_chk (.*);

// File: test/tb_gf2m_field_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf2m_field_arithmetic_unit_core
// Self-checking bench for the GF(2^m) arithmetic unit. It sweeps several
// reduction polynomials, including the degree extremes and a reducible one,
// and runs directed and random add, multiply, reduce and invert beats.
// Both handshakes idle at random. A local predictor computes every result,
// and the scoreboard compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_gf2m_field_arithmetic_unit_core;
    import gf2m_pkg::*;

    // Scoreboard with its own field predictor and copy of the configuration.
    class field_scoreboard;
        logic [FIELD_W-1:0] want_res[$];
        logic               want_err[$];
        logic [DEG_W-1:0]   deg_reg;
        logic [FIELD_W-1:0] tail_reg;
        int                 mismatches;

        function new();
            deg_reg    = DEG_RESET;
            tail_reg   = TAIL_RESET;
            mismatches = 0;
        endfunction

        function int eff_deg();
            if (deg_reg < DEG_MIN)
            begin
                return DEG_MIN;
            end
            if (deg_reg > DEG_MAX)
            begin
                return DEG_MAX;
            end
            return deg_reg;
        endfunction

        function logic [FIELD_W-1:0] deg_mask(int d);
            if (d == 64)
            begin
                return '1;
            end
            return (64'd1 << d) - 64'd1;
        endfunction

        // Multiply a reduced value by x modulo P.
        function logic [FIELD_W-1:0] shift_x(logic [FIELD_W-1:0] g, int d,
                                             logic [FIELD_W-1:0] tm);
            logic top;
            top = g[d-1];
            g = (g << 1) & deg_mask(d);
            if (top)
            begin
                g = g ^ tm;
            end
            return g;
        endfunction

        // Horner reduction of a 128-bit polynomial, top coefficient first.
        function logic [FIELD_W-1:0] fold(logic [127:0] p, int d, logic [FIELD_W-1:0] tm);
            logic [FIELD_W-1:0] r;
            r = '0;
            for (int i = 127; i >= 0; i--)
            begin
                r = shift_x(r, d, tm) ^ {63'd0, p[i]};
            end
            return r;
        endfunction

        function int top_bit(logic [127:0] p);
            int dg;
            dg = -1;
            for (int i = 0; i < 128; i++)
            begin
                if (p[i])
                begin
                    dg = i;
                end
            end
            return dg;
        endfunction

        // Extended Euclid; returns 0 when no inverse exists.
        function bit inverse(logic [FIELD_W-1:0] ar, int d, logic [FIELD_W-1:0] tm,
                             output logic [FIELD_W-1:0] inv);
            logic [127:0]       u, v, t;
            logic [FIELD_W-1:0] g1, g2, gt, gs;
            int                 j;
            u  = {64'd0, ar};
            v  = (d == 64) ? {64'd1, tm} : ({64'd0, tm} | (128'd1 << d));
            g1 = 64'd1;
            g2 = '0;
            inv = '0;
            while (u != 128'd1)
            begin
                if (u == '0)
                begin
                    return 1'b0;
                end
                j = top_bit(u) - top_bit(v);
                if (j < 0)
                begin
                    t = u; u = v; v = t;
                    gt = g1; g1 = g2; g2 = gt;
                    j = -j;
                end
                u = u ^ (v << j);
                gs = g2;
                for (int k = 0; k < j; k++)
                begin
                    gs = shift_x(gs, d, tm);
                end
                g1 = g1 ^ gs;
            end
            inv = g1;
            return 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
            if (idx == CFG_POLY_DEGREE)
            begin
                deg_reg = data[DEG_W-1:0];
            end
            else
            begin
                tail_reg = data;
            end
        endfunction

        // Note an accepted input beat and queue its predicted result.
        function void note_input(logic [1:0] opc, logic [FIELD_W-1:0] a,
                                 logic [FIELD_W-1:0] b);
            int                 d;
            logic [FIELD_W-1:0] tm, res, ar;
            logic [127:0]       prod;
            logic               err;
            d   = eff_deg();
            tm  = tail_reg & deg_mask(d);
            err = 1'b0;
            case (opc)
                OP_ADD: res = fold({64'd0, a ^ b}, d, tm);
                OP_MUL:
                begin
                    prod = '0;
                    for (int i = 0; i < 64; i++)
                    begin
                        if (b[i])
                        begin
                            prod = prod ^ ({64'd0, a} << i);
                        end
                    end
                    res = fold(prod, d, tm);
                end
                OP_RED: res = fold({64'd0, a}, d, tm);
                default:
                begin
                    ar = fold({64'd0, a}, d, tm);
                    if (!inverse(ar, d, tm, res))
                    begin
                        res = '0;
                        err = 1'b1;
                    end
                end
            endcase
            want_res.push_back(res);
            want_err.push_back(err);
        endfunction

        // Check an output beat against the oldest prediction.
        function void check_output(logic [FIELD_W-1:0] res, logic err);
            logic [FIELD_W-1:0] er;
            logic               ee;
            if (want_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected output beat: result=%h error=%b", res, err);
                end
                return;
            end
            er = want_res.pop_front();
            ee = want_err.pop_front();
            if (res !== er || err !== ee)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected result=%h error=%b, got result=%h error=%b",
                             er, ee, res, err);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic [FIELD_W-1:0]   operand_a;
    logic [FIELD_W-1:0]   operand_b;
    logic                 out_valid;
    logic                 out_ready;
    logic [FIELD_W-1:0]   result;
    logic                 error;

    field_scoreboard sb;
    bit              hold_req;
    int              cycles;

    gf2m_field_arithmetic_unit_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .error     (error)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_gf2m_field_arithmetic_unit_core: FAIL");
            $finish;
        end
    end

    // Beat monitors on both channels.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_input(op, operand_a, operand_b);
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_output(result, error);
        end
    end

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                if (out_valid)
                begin
                    break;
                end
            end
        end
    end

    // Offer one input beat, after a random gap unless burst is set; returns at the accepting edge.
    task automatic send_beat(logic [1:0] opc, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                             bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= opc;
        operand_a <= a;
        operand_b <= b;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                break;
            end
        end
        @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        // Let the monitor note the last accepted beat before polling the queue.
        @(posedge clk);
        while (sb.want_res.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand64();
        logic [FIELD_W-1:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = v & 64'hFF;
            1: v = v & 64'hFFFF;
            2: v = '1;
            3: v = {63'd0, v[0]};
            default: ;
        endcase
        return v;
    endfunction

    // Random mix of operations under the current polynomial.
    task automatic random_phase(int count);
        bit burst;
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                burst = ($urandom_range(0, 2) == 0);
            end
            send_beat(2'($urandom_range(0, 3)), rand64(), rand64(), burst);
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [DEG_W-1:0]   degs[8];
        logic [FIELD_W-1:0] tails[8];
        sb        = new();
        hold_req  = 1'b0;
        cycles    = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POLY_DEGREE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = OP_ADD;
        operand_a = '0;
        operand_b = '0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset polynomial.
        send_beat(OP_ADD, '0, '0, 1'b0);
        send_beat(OP_ADD, '1, '0, 1'b0);
        send_beat(OP_ADD, '1, '1, 1'b0);
        send_beat(OP_MUL, '1, '1, 1'b0);
        send_beat(OP_MUL, 64'h80, 64'h2, 1'b0);
        send_beat(OP_MUL, '0, '1, 1'b0);
        send_beat(OP_RED, '1, '0, 1'b0);
        send_beat(OP_RED, 64'h100, '1, 1'b0);
        send_beat(OP_INV, 64'd1, '0, 1'b0);
        send_beat(OP_INV, '0, '1, 1'b0);
        send_beat(OP_INV, 64'h11B, '0, 1'b0);
        send_beat(OP_INV, '1, '0, 1'b0);
        send_beat(OP_INV, 64'h53, '0, 1'b0);
        drain();

        // Reducible polynomial x^8: even values have no inverse.
        write_cfg(CFG_POLY_TAIL, 64'd0);
        send_beat(OP_INV, 64'h4, '0, 1'b0);
        send_beat(OP_INV, 64'h3, '0, 1'b0);
        drain();

        // Widest field, with tail bits beyond nothing to ignore.
        write_cfg(CFG_POLY_DEGREE, 64'd64);
        write_cfg(CFG_POLY_TAIL, 64'h1B);
        send_beat(OP_MUL, '1, '1, 1'b0);
        send_beat(OP_INV, '1, '0, 1'b0);
        send_beat(OP_INV, 64'h8000_0000_0000_0000, '0, 1'b0);
        send_beat(OP_ADD, '1, 64'h5555_5555_5555_5555, 1'b0);
        drain();

        // Degree below range acts as the smallest field; tail bits above ignored.
        write_cfg(CFG_POLY_DEGREE, 64'hFFFF_FFFF_FFFF_FF80);
        write_cfg(CFG_POLY_TAIL, '1);
        send_beat(OP_INV, 64'd2, '0, 1'b0);
        send_beat(OP_MUL, '1, 64'd3, 1'b0);
        send_beat(OP_RED, '1, '0, 1'b0);
        drain();

        // Random phases across several polynomials.
        degs[0] = 7'd8;   tails[0] = 64'd27;
        degs[1] = 7'd64;  tails[1] = 64'h1B;
        degs[2] = 7'd2;   tails[2] = 64'd3;
        degs[3] = 7'd1;   tails[3] = rand64();
        degs[4] = 7'd127; tails[4] = rand64();
        degs[5] = 7'd16;  tails[5] = 64'd0;
        degs[6] = 7'($urandom_range(3, 63)); tails[6] = {$urandom(), $urandom()};
        degs[7] = 7'd64;  tails[7] = '1;
        for (int p = 0; p < 8; p++)
        begin
            write_cfg(CFG_POLY_DEGREE, {57'd0, degs[p]});
            write_cfg(CFG_POLY_TAIL, tails[p]);
            if (p == 2)
            begin
                hold_req = 1'b1;
                random_phase(20);
            end
            random_phase(165);
            drain();
        end

        if (sb.mismatches == 0 && sb.want_res.size() == 0)
        begin
            $display("tb_gf2m_field_arithmetic_unit_core: PASS");
        end
        else
        begin
            $display("tb_gf2m_field_arithmetic_unit_core: FAIL");
        end
        $finish;
    end

endmodule
